[hw/rtl/i2cmee_pkg.sv]
// Shared types and constants for the I2C master register block with its EEPROM slave model.
// Holds the payload structs, the transfer phase enum, the register map and the size mask.
// Depends on nothing; the top level takes everything from here by scoped names.
package i2cmee_pkg;

  localparam int unsigned FIFO_DEPTH_DEF  = 8;
  localparam int unsigned MEMORY_SIZE_DEF = 256;

  localparam logic [6:0] SLAVE_ADDR_RST = 7'd80;
  localparam logic [7:0] MEM_RESET_BASE = 8'hA0;
  localparam logic [7:0] RX_EMPTY_BYTE  = 8'hFF;

  // Register offsets.
  localparam logic [7:0] REG_CTRL   = 8'h00;
  localparam logic [7:0] REG_DIV    = 8'h04;
  localparam logic [7:0] REG_TX     = 8'h08;
  localparam logic [7:0] REG_RX     = 8'h0C;
  localparam logic [7:0] REG_STATUS = 8'h10;
  localparam logic [7:0] REG_IE     = 8'h14;
  localparam logic [7:0] REG_IS     = 8'h18;
  localparam logic [7:0] REG_CAP    = 8'h1C;

  // Access direction.
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // CTRL action bits; they are never stored.
  localparam int unsigned CTRL_BIT_START = 1;
  localparam int unsigned CTRL_BIT_STOP  = 2;
  localparam int unsigned CTRL_BIT_RD    = 3;
  localparam logic [31:0] CTRL_ACTION_MASK = 32'h0000_000E;

  // Interrupt enable and status bits.
  localparam int unsigned IRQ_RX   = 0;
  localparam int unsigned IRQ_TXE  = 1;
  localparam int unsigned IRQ_STOP = 2;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_ADDR = 2'd1,
    PH_DATA = 2'd2
  } phase_e;

  typedef struct packed {
    logic        operation;
    logic [7:0]  byte_offset;
    logic [3:0]  access_size;
    logic [31:0] write_data;
  } req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        bus_error;
    logic        irq_level;
  } rsp_t;

  // Byte lanes covered by an access of the given size.
  function automatic logic [31:0] size_mask(logic [3:0] size);
    logic [31:0] m;
    case (size)
      4'd0:    m = 32'h0000_0000;
      4'd1:    m = 32'h0000_00FF;
      4'd2:    m = 32'h0000_FFFF;
      4'd3:    m = 32'h00FF_FFFF;
      default: m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage

[hw/rtl/i2c_master_eeprom_register_model.sv]
// Top level of the I2C master register block with a simulated EEPROM slave on its bus.
// Uses i2cmee_pkg for payload types, register map, phase enum and the size mask.
// Contains the request register, the access logic, the EEPROM and RX FIFO storage.

// One bus access is accepted every cycle while the response is not stalled; it is
// decoded from the request register and its response is loaded into the response
// register once that register is free or being taken. A stalled response lets at most
// one further access into the request register before the input stalls. The EEPROM
// byte at the current pointer and the RX FIFO head byte are read ahead from their
// registered read ports, so each access finishes in a single pass. The EEPROM has a
// valid bit per entry, so it reads its reset contents (0xA0 plus index) straight after
// reset, with no clearing pass. The slave address is written through the cfg port,
// which is always ready.
module i2c_master_eeprom_register_model #(
  parameter int unsigned FIFO_DEPTH  = i2cmee_pkg::FIFO_DEPTH_DEF,
  parameter int unsigned MEMORY_SIZE = i2cmee_pkg::MEMORY_SIZE_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  i2cmee_pkg::req_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output i2cmee_pkg::rsp_t  out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [6:0]        cfg_data_i
);

  localparam int unsigned HEAD_W = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W  = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned IDX_W  = $clog2(MEMORY_SIZE);
  localparam logic [31:0] CAP_VALUE =
      32'((1 << 16) | (FIFO_DEPTH << 8) | FIFO_DEPTH);

  // Request stage and response register.
  logic             s1_valid_q;
  i2cmee_pkg::req_t s1_q;
  logic             s1_fire;
  logic             out_valid_q;
  i2cmee_pkg::rsp_t out_q;
  i2cmee_pkg::rsp_t rsp_d;

  // Architectural state.
  logic [6:0]          addr_q;
  logic [31:0]         ctrl_q, ctrl_d;
  logic [31:0]         div_q, div_d;
  logic [2:0]          ie_q, ie_d;
  logic [2:0]          is_q, is_d;
  i2cmee_pkg::phase_e  phase_q, phase_d;
  logic                dir_q, dir_d;
  logic [7:0]          ptr_q, ptr_d;
  logic                ack_q, ack_d;
  logic                irq_q, irq_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [HEAD_W-1:0]   head_q, head_d;

  // EEPROM storage with per-entry valid bits and a registered read port.
  logic [7:0]             mem_q [MEMORY_SIZE];
  logic [MEMORY_SIZE-1:0] mem_valid_q;
  logic [7:0]             mem_rdata_q;
  logic                   mem_rvalid_q;
  logic [IDX_W-1:0]       mem_idx_q;
  logic [IDX_W-1:0]       rd_idx;
  logic [IDX_W-1:0]       idx_tbl [256];
  logic [7:0]             mem_byte;
  logic                   mem_we;
  logic                   mem_fwd;
  logic [7:0]             tx_byte;

  // RX FIFO storage with a registered head read.
  logic [7:0]          fifo_q [FIFO_DEPTH];
  logic [7:0]          fifo_rdata_q;
  logic                fifo_we;
  logic [CNT_W:0]      wr_sum;
  logic [HEAD_W-1:0]   wr_idx;
  logic [HEAD_W-1:0]   head_inc;

  // Pointer modulo memory size, worked out at elaboration.
  for (genvar g = 0; g < 256; g++) begin : g_idx_tbl
    assign idx_tbl[g] = IDX_W'(g % MEMORY_SIZE);
  end

  assign cfg_ready_o = 1'b1;
  assign s1_fire     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !s1_valid_q || s1_fire;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign mem_byte = mem_rvalid_q ? mem_rdata_q
                                 : 8'(i2cmee_pkg::MEM_RESET_BASE + 8'(mem_idx_q));
  assign rd_idx   = idx_tbl[ptr_d];
  assign mem_fwd  = mem_we && (mem_idx_q == rd_idx);

  assign wr_sum   = (CNT_W + 1)'(head_q) + (CNT_W + 1)'(cnt_q);
  assign wr_idx   = (wr_sum >= (CNT_W + 1)'(FIFO_DEPTH))
                    ? HEAD_W'(wr_sum - (CNT_W + 1)'(FIFO_DEPTH)) : HEAD_W'(wr_sum);
  assign head_inc = (head_q == HEAD_W'(FIFO_DEPTH - 1)) ? '0 : head_q + 1'b1;

  // Interrupt evaluation: returns {line, status}. A pending stop interrupt is
  // consumed when it drives the line.
  function automatic logic [3:0] irq_eval(logic [2:0] is, logic [2:0] ie, logic rx_nz);
    logic       stop_p;
    logic [2:0] is_n;
    stop_p = ie[i2cmee_pkg::IRQ_STOP] && is[i2cmee_pkg::IRQ_STOP];
    is_n   = is;
    if (stop_p) begin
      is_n[i2cmee_pkg::IRQ_STOP] = 1'b0;
    end
    return {stop_p || (ie[i2cmee_pkg::IRQ_RX] && rx_nz), is_n};
  endfunction

  always_comb begin
    logic [31:0] mask;
    logic [31:0] wv;
    logic [31:0] rdata;
    logic        err;
    logic [3:0]  ev;
    ctrl_d  = ctrl_q;
    div_d   = div_q;
    ie_d    = ie_q;
    is_d    = is_q;
    phase_d = phase_q;
    dir_d   = dir_q;
    ptr_d   = ptr_q;
    ack_d   = ack_q;
    irq_d   = irq_q;
    cnt_d   = cnt_q;
    head_d  = head_q;
    mem_we  = 1'b0;
    fifo_we = 1'b0;
    mask    = i2cmee_pkg::size_mask(s1_q.access_size);
    wv      = s1_q.write_data & mask;
    tx_byte = wv[7:0];
    rdata   = '0;
    err     = 1'b0;
    ev      = '0;
    if (s1_fire) begin
      if (s1_q.byte_offset > i2cmee_pkg::REG_CAP) begin
        err = 1'b1;
      end else if (s1_q.operation == i2cmee_pkg::OP_READ) begin
        case (s1_q.byte_offset)
          i2cmee_pkg::REG_CTRL: rdata = ctrl_q;
          i2cmee_pkg::REG_DIV:  rdata = div_q;
          i2cmee_pkg::REG_RX: begin
            rdata = {24'b0, i2cmee_pkg::RX_EMPTY_BYTE};
            if (cnt_q != '0) begin
              rdata  = {24'b0, fifo_rdata_q};
              head_d = head_inc;
              cnt_d  = cnt_q - 1'b1;
            end
            if (cnt_d == '0) begin
              is_d[i2cmee_pkg::IRQ_RX] = 1'b0;
            end
            ev    = irq_eval(is_d, ie_q, cnt_d != '0);
            is_d  = ev[2:0];
            irq_d = ev[3];
          end
          i2cmee_pkg::REG_STATUS: begin
            rdata = {28'b0, ack_q, cnt_q != '0, 1'b1, 1'b0};
            ev    = irq_eval(is_q, ie_q, cnt_q != '0);
            is_d  = ev[2:0];
            irq_d = ev[3];
          end
          i2cmee_pkg::REG_IE:  rdata = {29'b0, ie_q};
          i2cmee_pkg::REG_IS:  rdata = {29'b0, is_q};
          i2cmee_pkg::REG_CAP: rdata = CAP_VALUE;
          default:             rdata = '0;
        endcase
        rdata = rdata & mask;
      end else begin
        case (s1_q.byte_offset)
          i2cmee_pkg::REG_CTRL: begin
            ctrl_d = wv & ~i2cmee_pkg::CTRL_ACTION_MASK;
            if (wv[i2cmee_pkg::CTRL_BIT_START]) begin
              phase_d = i2cmee_pkg::PH_IDLE;
              ack_d   = 1'b0;
              is_d[i2cmee_pkg::IRQ_TXE] = 1'b1;
            end
            if (wv[i2cmee_pkg::CTRL_BIT_RD]) begin
              // The pointer advances even when the FIFO is full and the byte is lost.
              ptr_d = ptr_q + 8'd1;
              if (cnt_q < CNT_W'(FIFO_DEPTH)) begin
                fifo_we = 1'b1;
                cnt_d   = cnt_q + 1'b1;
                is_d[i2cmee_pkg::IRQ_RX] = 1'b1;
                ev    = irq_eval(is_d, ie_q, 1'b1);
                is_d  = ev[2:0];
                irq_d = ev[3];
              end
            end
            if (wv[i2cmee_pkg::CTRL_BIT_STOP]) begin
              phase_d = i2cmee_pkg::PH_IDLE;
              ack_d   = 1'b0;
              is_d[i2cmee_pkg::IRQ_STOP] = 1'b1;
              is_d[i2cmee_pkg::IRQ_TXE]  = 1'b1;
              ev    = irq_eval(is_d, ie_q, cnt_d != '0);
              is_d  = ev[2:0];
              irq_d = ev[3];
            end
          end
          i2cmee_pkg::REG_DIV: div_d = wv;
          i2cmee_pkg::REG_TX: begin
            case (phase_q)
              i2cmee_pkg::PH_IDLE: begin
                if (tx_byte[7:1] == addr_q) begin
                  dir_d   = ~tx_byte[0];
                  phase_d = i2cmee_pkg::PH_ADDR;
                  ack_d   = 1'b1;
                end else begin
                  ack_d = 1'b0;
                end
              end
              i2cmee_pkg::PH_ADDR: begin
                ptr_d   = tx_byte;
                phase_d = i2cmee_pkg::PH_DATA;
                ack_d   = 1'b1;
              end
              i2cmee_pkg::PH_DATA: begin
                if (dir_q) begin
                  mem_we = 1'b1;
                  ptr_d  = ptr_q + 8'd1;
                end
                ack_d = 1'b1;
              end
              default: ack_d = 1'b1;
            endcase
            is_d[i2cmee_pkg::IRQ_TXE] = 1'b1;
            ev    = irq_eval(is_d, ie_q, cnt_q != '0);
            is_d  = ev[2:0];
            irq_d = ev[3];
          end
          i2cmee_pkg::REG_IE: begin
            ie_d  = wv[2:0];
            ev    = irq_eval(is_q, wv[2:0], cnt_q != '0);
            is_d  = ev[2:0];
            irq_d = ev[3];
          end
          i2cmee_pkg::REG_IS: begin
            ev    = irq_eval(is_q & ~wv[2:0], ie_q, cnt_q != '0);
            is_d  = ev[2:0];
            irq_d = ev[3];
          end
          default: begin
          end
        endcase
      end
    end
    rsp_d.read_data = rdata;
    rsp_d.bus_error = err;
    rsp_d.irq_level = irq_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      addr_q       <= i2cmee_pkg::SLAVE_ADDR_RST;
      ctrl_q       <= '0;
      div_q        <= '0;
      ie_q         <= '0;
      is_q         <= '0;
      phase_q      <= i2cmee_pkg::PH_IDLE;
      dir_q        <= 1'b0;
      ptr_q        <= '0;
      ack_q        <= 1'b0;
      irq_q        <= 1'b0;
      cnt_q        <= '0;
      head_q       <= '0;
      mem_valid_q  <= '0;
      mem_rvalid_q <= 1'b0;
      mem_idx_q    <= '0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (s1_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        addr_q <= cfg_data_i;
      end
      ctrl_q  <= ctrl_d;
      div_q   <= div_d;
      ie_q    <= ie_d;
      is_q    <= is_d;
      phase_q <= phase_d;
      dir_q   <= dir_d;
      ptr_q   <= ptr_d;
      ack_q   <= ack_d;
      irq_q   <= irq_d;
      cnt_q   <= cnt_d;
      head_q  <= head_d;
      if (mem_we) begin
        mem_valid_q[mem_idx_q] <= 1'b1;
      end
      // When the memory size divides 255, a write at the last pointer value lands on the
      // entry that the wrapped pointer prefetches, so the written byte is forwarded.
      mem_rvalid_q <= mem_valid_q[rd_idx] || mem_fwd;
      mem_idx_q    <= rd_idx;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_q <= in_data_i;
    end
    if (s1_fire) begin
      out_q <= rsp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_idx_q] <= tx_byte;
    end
    if (mem_fwd) begin
      mem_rdata_q <= tx_byte;
    end else begin
      mem_rdata_q <= mem_q[rd_idx];
    end
  end

  // A push into an empty FIFO lands at the head, so it is forwarded to the head read.
  always_ff @(posedge clk_i) begin
    if (fifo_we) begin
      fifo_q[wr_idx] <= mem_byte;
    end
    if (fifo_we && (wr_idx == head_d)) begin
      fifo_rdata_q <= mem_byte;
    end else begin
      fifo_rdata_q <= fifo_q[head_d];
    end
  end

endmodule
